// ----- rtl/core/bai_pkg.sv -----
// Shared codes and cell control types for the bounded array list.
package bai_pkg;

	// Request operation codes
	localparam logic [2:0] OP_APPEND      = 3'd0;
	localparam logic [2:0] OP_REMOVE_LAST = 3'd1;
	localparam logic [2:0] OP_INSERT      = 3'd2;
	localparam logic [2:0] OP_DELETE      = 3'd3;
	localparam logic [2:0] OP_CLEAR       = 3'd4;
	localparam logic [2:0] OP_READ        = 3'd5;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SIZE  = 2'd1;
	localparam logic [1:0] ST_INDEX = 2'd2;

	// Field widths fixed by the stream format
	localparam int OP_W     = 3;
	localparam int POS_W    = 6;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	// Command broadcast to every cell
	typedef logic [1:0] cell_cmd_t;
	localparam cell_cmd_t CMD_HOLD   = 2'd0;
	localparam cell_cmd_t CMD_APPEND = 2'd1;
	localparam cell_cmd_t CMD_INSERT = 2'd2;
	localparam cell_cmd_t CMD_DELETE = 2'd3;

	typedef struct packed {
		cell_cmd_t        cmd;
		logic [POS_W-1:0] pos;
	} cell_ctl_t;

endpackage

// ----- rtl/core/bai_cell.sv -----
// One storage cell of the list: holds an entry and trades it with its neighbors.
module bai_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int IDX_W      = 6,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  bai_pkg::cell_ctl_t    ctl,
	input  logic [IDX_W-1:0]      tail,
	input  logic [DATA_WIDTH-1:0] word,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] q,
	output logic [DATA_WIDTH-1:0] rd
);

	localparam int CW = (IDX_W > bai_pkg::POS_W) ? IDX_W : bai_pkg::POS_W;
	localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

	logic [DATA_WIDTH-1:0] entry_q;
	logic [DATA_WIDTH-1:0] entry_d;
	logic [CW-1:0]         pos_w;
	logic [CW-1:0]         tail_w;

	assign pos_w  = CW'(ctl.pos);
	assign tail_w = CW'(tail);

	// Pick the next entry: write, shift up from the left, shift down from the right
	always_comb begin
		entry_d = entry_q;
		unique case (ctl.cmd)
			bai_pkg::CMD_APPEND: begin
				if (MY_IDX == tail_w) entry_d = word;
			end
			bai_pkg::CMD_INSERT: begin
				if (MY_IDX == pos_w) entry_d = word;
				else if (MY_IDX > pos_w) entry_d = left;
			end
			bai_pkg::CMD_DELETE: begin
				if (MY_IDX >= pos_w) entry_d = right;
			end
			default: entry_d = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign q  = entry_q;
	// Drive the read bus only when addressed
	assign rd = (MY_IDX == pos_w) ? entry_q : '0;

endmodule

// ----- rtl/core/bai_ctrl.sv -----
// Request decode, entry count, status and result register for the array list.
module bai_ctrl #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32,
	parameter int IDX_W      = 6,
	parameter int CNT_W      = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bai_pkg::OP_W-1:0]       op,
	input  logic [bai_pkg::POS_W-1:0]      pos,
	input  logic [DATA_WIDTH-1:0]          rd_word,
	output bai_pkg::cell_ctl_t             ctl,
	output logic [IDX_W-1:0]               tail,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bai_pkg::STATUS_W-1:0]   status,
	output logic [bai_pkg::WORD_W-1:0]     word_out,
	output logic [bai_pkg::COUNT_W-1:0]    count_now
);

	localparam int PW = (CNT_W > bai_pkg::POS_W) ? CNT_W : bai_pkg::POS_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic                            fire;
	logic [CNT_W-1:0]                count_q;
	logic [CNT_W-1:0]                count_d;
	logic [bai_pkg::STATUS_W-1:0]    status_d;
	logic [bai_pkg::WORD_W-1:0]      word_d;
	bai_pkg::cell_cmd_t              cmd_d;
	logic                            full;
	logic                            empty;
	logic                            pos_oob;
	logic                            out_valid_q;
	logic [bai_pkg::STATUS_W-1:0]    status_q;
	logic [bai_pkg::WORD_W-1:0]      word_q;
	logic [bai_pkg::COUNT_W-1:0]     count_now_q;

	// Accept while the result register is free or being drained
	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign pos_oob = (PW'(pos) >= PW'(count_q));

	// Decode the request against the current count
	always_comb begin
		count_d  = count_q;
		status_d = bai_pkg::ST_OK;
		word_d   = '0;
		cmd_d    = bai_pkg::CMD_HOLD;
		unique case (op)
			bai_pkg::OP_APPEND: begin
				if (full) status_d = bai_pkg::ST_SIZE;
				else begin
					cmd_d   = bai_pkg::CMD_APPEND;
					count_d = count_q + 1'b1;
				end
			end
			bai_pkg::OP_REMOVE_LAST: begin
				if (empty) status_d = bai_pkg::ST_SIZE;
				else count_d = count_q - 1'b1;
			end
			bai_pkg::OP_INSERT: begin
				if (full) status_d = bai_pkg::ST_SIZE;
				else if (pos_oob) status_d = bai_pkg::ST_INDEX;
				else begin
					cmd_d   = bai_pkg::CMD_INSERT;
					count_d = count_q + 1'b1;
				end
			end
			bai_pkg::OP_DELETE: begin
				if (empty) status_d = bai_pkg::ST_SIZE;
				else if (pos_oob) status_d = bai_pkg::ST_INDEX;
				else begin
					cmd_d   = bai_pkg::CMD_DELETE;
					count_d = count_q - 1'b1;
				end
			end
			bai_pkg::OP_CLEAR: begin
				count_d = '0;
			end
			bai_pkg::OP_READ: begin
				if (pos_oob) status_d = bai_pkg::ST_INDEX;
				else word_d = bai_pkg::WORD_W'(rd_word);
			end
			default: begin
				status_d = bai_pkg::ST_OK;
			end
		endcase
	end

	// Drive the cells only on an accepted transaction
	assign ctl.cmd = fire ? cmd_d : bai_pkg::CMD_HOLD;
	assign ctl.pos = pos;
	assign tail    = IDX_W'(count_q);

	// Hold the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_d;
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q    <= status_d;
			word_q      <= word_d;
			count_now_q <= bai_pkg::COUNT_W'(count_d);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign word_out  = word_q;
	assign count_now = count_now_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (op == bai_pkg::OP_CLEAR) |=> (count_q == '0))
		else $error("clear left entries behind");

	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (status_d != bai_pkg::ST_OK) |=> (count_q == $past(count_q)))
		else $error("failed request changed the count");

	a_word_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != bai_pkg::ST_OK) |-> (word_q == '0))
		else $error("word returned on a failed request");

	a_cells_idle_without_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |-> (ctl.cmd == bai_pkg::CMD_HOLD))
		else $error("cells moved without a transaction");
`endif

endmodule

// ----- rtl/core/bounded_array_insert_delete.sv -----
// Top level of the bounded array list: a row of entry cells under one controller.
//
//  channel  | dir | handshake          | tdata fields (low bit up)
//  ---------+-----+--------------------+------------------------------------------
//  request  | in  | s_tvalid/s_tready  | operation[2:0] position[8:3] word_in[40:9]
//  result   | out | m_tvalid/m_tready  | status[1:0] word_out[33:2] count_now[40:34]
//
// One request per cycle while m_tready takes the results; its result is registered and shows on m_tdata the next cycle.
// Insert and delete move the entries from the position upward one cell together; read selects
// through an AND-OR bus across the cells, which sets the longest path.
// Reset clears the count and the result valid flag; cell contents are not reset.
// A stalled result holds s_tready low until m_tready takes it.
module bounded_array_insert_delete #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // operation, position, word_in, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // status, word_out, count_now, zero pad
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [bai_pkg::OP_W-1:0]      op;
	logic [bai_pkg::POS_W-1:0]     pos;
	logic [bai_pkg::WORD_W-1:0]    word_in;
	logic [DATA_WIDTH-1:0]         word_cell;
	bai_pkg::cell_ctl_t            ctl;
	logic [IDX_W-1:0]              tail;
	logic [DATA_WIDTH-1:0]         cell_q  [DEPTH];
	logic [DATA_WIDTH-1:0]         cell_rd [DEPTH];
	logic [DATA_WIDTH-1:0]         rd_word;
	logic [bai_pkg::STATUS_W-1:0]  status;
	logic [bai_pkg::WORD_W-1:0]    word_out;
	logic [bai_pkg::COUNT_W-1:0]   count_now;

	// Unpack the request
	assign op        = s_tdata[2:0];
	assign pos       = s_tdata[8:3];
	assign word_in   = s_tdata[40:9];
	assign word_cell = DATA_WIDTH'(word_in);

	bai_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op        (op),
		.pos       (pos),
		.rd_word   (rd_word),
		.ctl       (ctl),
		.tail      (tail),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.word_out  (word_out),
		.count_now (count_now)
	);

	// Row of cells, each wired to its neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = cell_q[i];
		end else begin : g_mid_l
			assign left_w = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_q[i];
		end else begin : g_mid_r
			assign right_w = cell_q[i+1];
		end

		bai_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.IDX_W      (IDX_W),
			.INDEX      (i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.tail  (tail),
			.word  (word_cell),
			.left  (left_w),
			.right (right_w),
			.q     (cell_q[i]),
			.rd    (cell_rd[i])
		);
	end

	// Merge the read bus
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_word = rd_word | cell_rd[i];
		end
	end

	// Pack the result
	assign m_tdata = {7'd0, count_now, word_out, status};

endmodule

// ----- tb/bounded_array_insert_delete_test.sv -----
// Self-checking testbench for the bounded array list: directed table, then biased random traffic.
`timescale 1ns / 100ps

module bounded_array_insert_delete_test;

	localparam int LIST_DEPTH = 64;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int SEGMENTS = 14;
	localparam int SEGMENT_ITEMS = 100;

	// Spare operation codes the block must ignore
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	typedef enum int {MIX_GROW, MIX_READ, MIX_SHRINK, MIX_ANY} traffic_mix_t;

	typedef struct packed {
		logic [bai_pkg::STATUS_W-1:0] status;
		logic [bai_pkg::WORD_W-1:0]   word;
		logic [bai_pkg::COUNT_W-1:0]  count;
	} list_result_t;

	typedef struct packed {
		logic [bai_pkg::OP_W-1:0]   op;
		logic [bai_pkg::POS_W-1:0]  pos;
		logic [bai_pkg::WORD_W-1:0] word;
		bit                         typed;
		list_result_t               res;
	} request_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;  // operation, position, word_in, zero pad
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;       // status, word_out, count_now, zero pad

	// Shadow copy of the list kept by the predictor
	logic [bai_pkg::WORD_W-1:0]  list_words [0:LIST_DEPTH-1];
	logic [bai_pkg::COUNT_W-1:0] list_count;

	list_result_t pending_results [$];
	request_row_t directed_rows [$];
	int fail_count = 0;
	bit tx_gaps = 1'b1;
	bit rx_stalls = 1'b1;
	bit rx_hold_req = 1'b0;

	bounded_array_insert_delete dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the shadow list and work out its result
	task automatic predict_result(input logic [2:0] op, input logic [5:0] pos,
			input logic [31:0] word, output list_result_t res);
		int i;
		res.status = bai_pkg::ST_OK;
		res.word = '0;
		case (op)
			bai_pkg::OP_APPEND: begin
				if (list_count >= LIST_DEPTH) begin
					res.status = bai_pkg::ST_SIZE;
				end else begin
					list_words[list_count] = word;
					list_count = list_count + 1'b1;
				end
			end
			bai_pkg::OP_REMOVE_LAST: begin
				if (list_count == 0) res.status = bai_pkg::ST_SIZE;
				else list_count = list_count - 1'b1;
			end
			bai_pkg::OP_INSERT: begin
				if (list_count >= LIST_DEPTH) begin
					res.status = bai_pkg::ST_SIZE;
				end else if ({1'b0, pos} >= list_count) begin
					res.status = bai_pkg::ST_INDEX;
				end else begin
					for (i = list_count; i > pos; i--) list_words[i] = list_words[i-1];
					list_words[pos] = word;
					list_count = list_count + 1'b1;
				end
			end
			bai_pkg::OP_DELETE: begin
				if (list_count == 0) begin
					res.status = bai_pkg::ST_SIZE;
				end else if ({1'b0, pos} >= list_count) begin
					res.status = bai_pkg::ST_INDEX;
				end else begin
					list_count = list_count - 1'b1;
					for (i = pos; i < list_count; i++) list_words[i] = list_words[i+1];
				end
			end
			bai_pkg::OP_CLEAR: begin
				for (i = 0; i < LIST_DEPTH; i++) list_words[i] = '0;
				list_count = '0;
			end
			bai_pkg::OP_READ: begin
				if ({1'b0, pos} >= list_count) res.status = bai_pkg::ST_INDEX;
				else res.word = list_words[pos];
			end
			default: ;
		endcase
		res.count = list_count;
	endtask

	// Offer one request and wait for its transaction
	task automatic send_request(input logic [2:0] op, input logic [5:0] pos,
			input logic [31:0] word, input bit typed, input list_result_t typed_res);
		list_result_t res;
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, word, pos, op};
		do @(negedge clk); while (!s_tready);
		predict_result(op, pos, word, res);
		if (typed) res = typed_res;
		pending_results = {pending_results, res};
		@(posedge clk);
	endtask

	// Drop valid for a random burst now and then
	task automatic sender_gap();
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic add_row(input logic [2:0] op, input logic [5:0] pos, input logic [31:0] word,
			input bit typed, input logic [1:0] st, input logic [31:0] rd, input logic [6:0] cnt);
		request_row_t row;
		row.op = op;
		row.pos = pos;
		row.word = word;
		row.typed = typed;
		row.res.status = st;
		row.res.word = rd;
		row.res.count = cnt;
		directed_rows = {directed_rows, row};
	endtask

	// Pick a random request, biased by the traffic mix
	task automatic pick_request(input traffic_mix_t mix, output logic [2:0] op,
			output logic [5:0] pos, output logic [31:0] word);
		int roll;
		int w_app, w_ins, w_rd, w_del, w_rem, w_spare;
		case (mix)
			MIX_GROW:   begin w_app = 45; w_ins = 35; w_rd = 8;  w_del = 5;  w_rem = 4;  w_spare = 2; end
			MIX_READ:   begin w_app = 15; w_ins = 15; w_rd = 45; w_del = 12; w_rem = 8;  w_spare = 3; end
			MIX_SHRINK: begin w_app = 5;  w_ins = 5;  w_rd = 10; w_del = 40; w_rem = 37; w_spare = 2; end
			default:    begin w_app = 20; w_ins = 20; w_rd = 20; w_del = 18; w_rem = 15; w_spare = 4; end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < w_app) op = bai_pkg::OP_APPEND;
		else if (roll < w_app + w_ins) op = bai_pkg::OP_INSERT;
		else if (roll < w_app + w_ins + w_rd) op = bai_pkg::OP_READ;
		else if (roll < w_app + w_ins + w_rd + w_del) op = bai_pkg::OP_DELETE;
		else if (roll < w_app + w_ins + w_rd + w_del + w_rem) op = bai_pkg::OP_REMOVE_LAST;
		else if (roll < w_app + w_ins + w_rd + w_del + w_rem + w_spare)
			op = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
		else op = (mix == MIX_ANY) ? bai_pkg::OP_CLEAR : bai_pkg::OP_READ;

		// Mostly in range, sometimes just past the end, sometimes anywhere
		roll = $urandom_range(0, 9);
		if (list_count != 0 && roll < 8) pos = 6'($urandom_range(0, list_count - 1));
		else if (roll == 8 && list_count < LIST_DEPTH) pos = list_count[5:0];
		else pos = 6'($urandom_range(0, 63));

		roll = $urandom_range(0, 15);
		if (roll == 0) word = '0;
		else if (roll == 1) word = '1;
		else word = $urandom;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Compare each result transaction with the oldest prediction
	always @(negedge clk) begin
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no request outstanding: 0x%0h", m_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
				check_field("word_out", want.word, m_tdata[33:2]);
				check_field("count_now", 32'(want.count), 32'(m_tdata[40:34]));
			end
		end
	end

	// Result side: random stalls, one long hold-off on request
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Request side: reset, directed table, random segments, drain
	initial begin
		logic [2:0] op;
		logic [5:0] pos;
		logic [31:0] word;
		traffic_mix_t mix;
		list_result_t none;
		none = '0;
		for (int i = 0; i < LIST_DEPTH; i++) list_words[i] = '0;
		list_count = '0;

		// Empty list errors, extremes of the word, bounds of the index
		add_row(bai_pkg::OP_READ, 6'd0, 32'h0, 1, bai_pkg::ST_INDEX, 32'h0, 7'd0);
		add_row(bai_pkg::OP_REMOVE_LAST, 6'd0, 32'h0, 1, bai_pkg::ST_SIZE, 32'h0, 7'd0);
		add_row(bai_pkg::OP_DELETE, 6'd0, 32'h0, 1, bai_pkg::ST_SIZE, 32'h0, 7'd0);
		add_row(bai_pkg::OP_INSERT, 6'd0, 32'hFFFFFFFF, 1, bai_pkg::ST_INDEX, 32'h0, 7'd0);
		add_row(bai_pkg::OP_APPEND, 6'd63, 32'hFFFFFFFF, 1, bai_pkg::ST_OK, 32'h0, 7'd1);
		add_row(bai_pkg::OP_APPEND, 6'd0, 32'h0, 1, bai_pkg::ST_OK, 32'h0, 7'd2);
		add_row(bai_pkg::OP_READ, 6'd0, 32'h0, 1, bai_pkg::ST_OK, 32'hFFFFFFFF, 7'd2);
		add_row(bai_pkg::OP_READ, 6'd63, 32'h0, 1, bai_pkg::ST_INDEX, 32'h0, 7'd2);
		add_row(bai_pkg::OP_INSERT, 6'd1, 32'hA5A5A5A5, 0, bai_pkg::ST_OK, 32'h0, 7'd0);
		add_row(bai_pkg::OP_INSERT, 6'd0, 32'h5A5A5A5A, 0, bai_pkg::ST_OK, 32'h0, 7'd0);
		add_row(bai_pkg::OP_READ, 6'd2, 32'h0, 0, bai_pkg::ST_OK, 32'h0, 7'd0);
		add_row(bai_pkg::OP_DELETE, 6'd63, 32'h0, 1, bai_pkg::ST_INDEX, 32'h0, 7'd4);
		add_row(bai_pkg::OP_DELETE, 6'd3, 32'h0, 0, bai_pkg::ST_OK, 32'h0, 7'd0);
		add_row(bai_pkg::OP_DELETE, 6'd0, 32'h0, 0, bai_pkg::ST_OK, 32'h0, 7'd0);
		add_row(OP_SPARE_LO, 6'd63, 32'hFFFFFFFF, 0, bai_pkg::ST_OK, 32'h0, 7'd0);
		add_row(OP_SPARE_HI, 6'd0, 32'hFFFFFFFF, 0, bai_pkg::ST_OK, 32'h0, 7'd0);
		add_row(bai_pkg::OP_READ, 6'd1, 32'h0, 0, bai_pkg::ST_OK, 32'h0, 7'd0);
		add_row(bai_pkg::OP_REMOVE_LAST, 6'd0, 32'h0, 0, bai_pkg::ST_OK, 32'h0, 7'd0);
		add_row(bai_pkg::OP_APPEND, 6'd0, 32'h12345678, 0, bai_pkg::ST_OK, 32'h0, 7'd0);
		add_row(bai_pkg::OP_CLEAR, 6'd0, 32'h0, 1, bai_pkg::ST_OK, 32'h0, 7'd0);
		add_row(bai_pkg::OP_READ, 6'd0, 32'h0, 1, bai_pkg::ST_INDEX, 32'h0, 7'd0);
		add_row(bai_pkg::OP_APPEND, 6'd0, 32'h80000001, 1, bai_pkg::ST_OK, 32'h0, 7'd1);
		add_row(bai_pkg::OP_REMOVE_LAST, 6'd0, 32'h0, 1, bai_pkg::ST_OK, 32'h0, 7'd0);
		add_row(bai_pkg::OP_REMOVE_LAST, 6'd0, 32'h0, 1, bai_pkg::ST_SIZE, 32'h0, 7'd0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].word,
				directed_rows[i].typed, directed_rows[i].res);
			sender_gap();
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			mix = traffic_mix_t'(seg % 4);
			// Quiet stretches now and then, none at all near the end
			tx_gaps = (seg % 3 != 2) && (seg < SEGMENTS - 2);
			rx_stalls = (seg % 5 != 3) && (seg < SEGMENTS - 2);
			if (seg == 5) rx_hold_req = 1'b1;
			for (int n = 0; n < SEGMENT_ITEMS; n++) begin
				pick_request(mix, op, pos, word);
				send_request(op, pos, word, 0, none);
				sender_gap();
			end
		end
		s_tvalid <= 1'b0;

		// Drain outstanding results, then allow a few more cycles
		while (pending_results.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#3000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
